// ===== rtl/core/excluded_rect_span_generator_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the exclusion rectangle span generator
// Short forms for clocked implication checks with a synchronous reset.
// ----------------------------------------------------------------------------
`ifndef EXCLUDED_RECT_SPAN_GENERATOR_CORE_ASSERT_SVH
`define EXCLUDED_RECT_SPAN_GENERATOR_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ERSPG_ASSERT_IMPLY(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ERSPG_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);

`endif

// ===== rtl/core/erspg_pkg.sv =====
// ----------------------------------------------------------------------------
// erspg_pkg
// Field widths, codes and the command and status bundles shared by the
// exclusion rectangle span generator.
// ----------------------------------------------------------------------------
package erspg_pkg;

   // Fixed widths of the channel fields.
   localparam int ACTION_W  = 2;
   localparam int RECT_W    = 16;
   localparam int ROW_W     = 12;
   localparam int START_W   = 12;
   localparam int LEN_W     = 13;
   localparam int CFG_W     = 13;
   localparam int CSR_IDX_W = 1;

   // Register values after reset.
   localparam logic [CFG_W-1:0] FRAME_WIDTH_RESET  = 13'd640;
   localparam logic [CFG_W-1:0] FRAME_HEIGHT_RESET = 13'd480;

   // Request action codes.
   typedef enum logic [ACTION_W-1:0] {
      ACT_CLEAR  = 2'd0,
      ACT_APPEND = 2'd1,
      ACT_ROW    = 2'd2
   } action_type;

   // Configuration register indexes.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FRAME_WIDTH  = 1'b0,
      CSR_FRAME_HEIGHT = 1'b1
   } csr_index_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic clear;
      logic append;
      logic start;
      logic advance;
      logic pend_load;
      logic sel_tail;
      logic out_load;
      logic out_marker;
      logic out_last;
   } erspg_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic walk_done;
      logic walk_gap;
      logic tail_gap;
      logic out_free;
   } erspg_status_type;

endpackage

// ===== rtl/core/erspg_ifs.sv =====
// ----------------------------------------------------------------------------
// erspg channel interfaces
// Valid/ready channels for requests, span results and register writes.
// ----------------------------------------------------------------------------

// Request channel: one table action or row request per transaction.
interface erspg_req_if;
   import erspg_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [ACTION_W-1:0]      action;
   logic signed [RECT_W-1:0] rect_left;
   logic signed [RECT_W-1:0] rect_top;
   logic signed [RECT_W-1:0] rect_right;
   logic signed [RECT_W-1:0] rect_bottom;
   logic [ROW_W-1:0]         row_index;

   modport source (output valid, action, rect_left, rect_top, rect_right,
                   rect_bottom, row_index, input ready);
   modport sink (input valid, action, rect_left, rect_top, rect_right,
                 rect_bottom, row_index, output ready);
endinterface

// Result channel: one span or row marker per transaction.
interface erspg_rsp_if;
   import erspg_pkg::*;

   logic               valid;
   logic               ready;
   logic [START_W-1:0] span_start;
   logic [ROW_W-1:0]   span_row;
   logic [LEN_W-1:0]   span_length;
   logic               span_valid;
   logic               last_span;
   logic               table_overflow;

   modport source (output valid, span_start, span_row, span_length, span_valid,
                   last_span, table_overflow, input ready);
   modport sink (input valid, span_start, span_row, span_length, span_valid,
                 last_span, table_overflow, output ready);
endinterface

// Register write channel.
interface erspg_csr_if;
   import erspg_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [CFG_W-1:0]     data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/core/erspg_ctrl.sv =====
// ----------------------------------------------------------------------------
// erspg_ctrl
// Controller: accepts requests and sequences the table walk, the tail span
// and the hand-off of held spans to the output register.
// ----------------------------------------------------------------------------
module erspg_ctrl (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic [erspg_pkg::ACTION_W-1:0]  req_action,
   output logic                            req_ready,
   input  erspg_pkg::erspg_status_type     status,
   output erspg_pkg::erspg_cmd_type        cmd
);
   import erspg_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_WALK  = 4'b0010,
      ST_TAIL  = 4'b0100,
      ST_FLUSH = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic      pend_valid_ff, pend_valid_in;

   // State and the held-span flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         pend_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   // A span is held back one step so that the final one can be flagged last.
   always_comb begin
      state_in      = state_ff;
      pend_valid_in = pend_valid_ff;
      cmd           = '0;
      req_ready     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               unique case (req_action)
                  ACT_CLEAR:  cmd.clear = 1'b1;
                  ACT_APPEND: cmd.append = 1'b1;
                  ACT_ROW: begin
                     cmd.start     = 1'b1;
                     pend_valid_in = 1'b0;
                     state_in      = ST_WALK;
                  end
                  default: ;
               endcase
            end
         end
         ST_WALK: begin
            if (status.walk_done) begin
               state_in = ST_TAIL;
            end else if (!(status.walk_gap && pend_valid_ff && !status.out_free)) begin
               cmd.advance = 1'b1;
               if (status.walk_gap) begin
                  cmd.pend_load = 1'b1;
                  pend_valid_in = 1'b1;
                  cmd.out_load  = pend_valid_ff;
               end
            end
         end
         ST_TAIL: begin
            if (status.out_free || (!pend_valid_ff && status.tail_gap)) begin
               if (pend_valid_ff) begin
                  cmd.out_load = 1'b1;
                  cmd.out_last = !status.tail_gap;
               end else if (!status.tail_gap) begin
                  cmd.out_load   = 1'b1;
                  cmd.out_marker = 1'b1;
                  cmd.out_last   = 1'b1;
               end
               if (status.tail_gap) begin
                  cmd.pend_load = 1'b1;
                  cmd.sel_tail  = 1'b1;
                  pend_valid_in = 1'b1;
                  state_in      = ST_FLUSH;
               end else begin
                  pend_valid_in = 1'b0;
                  state_in      = ST_IDLE;
               end
            end
         end
         ST_FLUSH: begin
            if (status.out_free) begin
               cmd.out_load  = 1'b1;
               cmd.out_last  = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

// ===== rtl/core/erspg_dp.sv =====
// ----------------------------------------------------------------------------
// erspg_dp
// Datapath: frame registers, rectangle clipping, the rectangle table memory,
// the row cursor, the held span and the output register.
// ----------------------------------------------------------------------------
module erspg_dp #(
   parameter int MAX_RECTS  = 16,
   parameter int COORD_BITS = 13
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic signed [erspg_pkg::RECT_W-1:0]  req_rect_left,
   input  logic signed [erspg_pkg::RECT_W-1:0]  req_rect_top,
   input  logic signed [erspg_pkg::RECT_W-1:0]  req_rect_right,
   input  logic signed [erspg_pkg::RECT_W-1:0]  req_rect_bottom,
   input  logic [erspg_pkg::ROW_W-1:0]          req_row_index,
   input  logic                                 csr_valid,
   input  logic [erspg_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [erspg_pkg::CFG_W-1:0]          csr_data,
   input  erspg_pkg::erspg_cmd_type             cmd,
   output erspg_pkg::erspg_status_type          status,
   input  logic                                 rsp_ready,
   output logic                                 rsp_valid,
   output logic [erspg_pkg::START_W-1:0]        rsp_span_start,
   output logic [erspg_pkg::ROW_W-1:0]          rsp_span_row,
   output logic [erspg_pkg::LEN_W-1:0]          rsp_span_length,
   output logic                                 rsp_span_valid,
   output logic                                 rsp_last_span,
   output logic                                 rsp_table_overflow
);
   import erspg_pkg::*;

   localparam int AW  = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
   localparam int CW  = $clog2(MAX_RECTS + 1);
   localparam int CB  = COORD_BITS;
   localparam int EW  = 4 * CB;
   // Wide enough for the signed input edges and for the frame cap.
   localparam int SW  = ((CB > RECT_W) ? CB : RECT_W) + 2;
   localparam int CAP = 1 << (CB - 1);
   localparam logic signed [SW-1:0] CAP_S = SW'(CAP);
   localparam logic [CW-1:0]        DEPTH = CW'(MAX_RECTS);

   logic [CFG_W-1:0]      frame_width_ff, frame_height_ff;
   logic signed [SW-1:0]  fw_s, fh_s, w_s, h_s;
   logic [CB-1:0]         w_cap;
   logic signed [SW-1:0]  l_s, t_s, r_s, b_s;
   logic signed [SW-1:0]  cl_left, cl_top, cl_right, cl_bottom;
   logic                  clip_empty;
   logic [EW-1:0]         entry;
   logic [EW-1:0]         mem [MAX_RECTS];
   logic [EW-1:0]         rd_data_ff;
   logic [AW-1:0]         rd_addr;
   logic                  rd_ok;
   logic                  wr_en;
   logic [CW-1:0]         count_ff;
   logic                  overflow_ff;
   logic [CW-1:0]         idx_ff, idx_in;
   logic [CB-1:0]         cursor_ff;
   logic [ROW_W-1:0]      row_ff;
   logic                  row_ok_ff, row_ok_req;
   logic [CB-1:0]         e_left, e_top, e_right, e_bottom;
   logic [SW-1:0]         row_u, top_u, bot_u;
   logic                  hit;
   logic [CB-1:0]         gap_end;
   logic [SW-1:0]         cursor_u, gap_len;
   logic [START_W-1:0]    pend_start_ff;
   logic [LEN_W-1:0]      pend_len_ff;
   logic                  rsp_valid_ff;

   // Frame registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= FRAME_WIDTH_RESET;
         frame_height_ff <= FRAME_HEIGHT_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_FRAME_WIDTH:  frame_width_ff <= csr_data;
            CSR_FRAME_HEIGHT: frame_height_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Frame size capped to what the coordinate width can address.
   assign fw_s  = signed'(SW'(frame_width_ff));
   assign fh_s  = signed'(SW'(frame_height_ff));
   assign w_s   = (fw_s > CAP_S) ? CAP_S : fw_s;
   assign h_s   = (fh_s > CAP_S) ? CAP_S : fh_s;
   assign w_cap = w_s[CB-1:0];

   // Clip the appended rectangle to the frame; an empty result stores zeros.
   assign l_s        = SW'(req_rect_left);
   assign t_s        = SW'(req_rect_top);
   assign r_s        = SW'(req_rect_right);
   assign b_s        = SW'(req_rect_bottom);
   assign cl_left    = (l_s < 0) ? '0 : l_s;
   assign cl_top     = (t_s < 0) ? '0 : t_s;
   assign cl_right   = (r_s > w_s) ? w_s : r_s;
   assign cl_bottom  = (b_s > h_s) ? h_s : b_s;
   assign clip_empty = (cl_left >= cl_right) || (cl_top >= cl_bottom);
   assign entry      = clip_empty ? '0 : {cl_left[CB-1:0], cl_top[CB-1:0],
                                          cl_right[CB-1:0], cl_bottom[CB-1:0]};

   // Table fill level and the sticky overflow flag.
   assign wr_en = cmd.append && (count_ff < DEPTH);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         overflow_ff <= 1'b0;
      end else if (cmd.clear) begin
         count_ff    <= '0;
         overflow_ff <= 1'b0;
      end else if (cmd.append) begin
         if (wr_en) begin
            count_ff <= count_ff + CW'(1);
         end else begin
            overflow_ff <= 1'b1;
         end
      end
   end

   // Walk index; the memory is addressed with its next value so that the
   // registered read data belongs to the current index.
   always_comb begin
      if (cmd.start) begin
         idx_in = '0;
      end else if (cmd.advance) begin
         idx_in = idx_ff + CW'(1);
      end else begin
         idx_in = idx_ff;
      end
   end

   assign rd_addr = idx_in[AW-1:0];
   assign rd_ok   = idx_in < DEPTH;

   // Rectangle table: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[count_ff[AW-1:0]] <= entry;
      end
      if (rd_ok) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // Row request state.
   assign row_ok_req = (signed'(SW'(req_row_index)) < h_s) && (w_s != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff    <= '0;
         row_ok_ff <= 1'b0;
      end else begin
         idx_ff <= idx_in;
         if (cmd.start) begin
            row_ok_ff <= row_ok_req;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         row_ff    <= req_row_index;
         cursor_ff <= '0;
      end else if (cmd.advance && hit) begin
         cursor_ff <= e_right;
      end
   end

   // Evaluate the current table entry against the row.
   assign e_left   = rd_data_ff[4*CB-1 -: CB];
   assign e_top    = rd_data_ff[3*CB-1 -: CB];
   assign e_right  = rd_data_ff[2*CB-1 -: CB];
   assign e_bottom = rd_data_ff[CB-1:0];
   assign row_u    = SW'(row_ff);
   assign top_u    = SW'(e_top);
   assign bot_u    = SW'(e_bottom);
   assign hit      = (e_left < e_right) && (e_top < e_bottom) &&
                     (top_u <= row_u) && (row_u < bot_u);

   assign status.walk_done = (idx_ff == count_ff) || !row_ok_ff;
   assign status.walk_gap  = hit && (e_left > cursor_ff);
   assign status.tail_gap  = row_ok_ff && (w_cap > cursor_ff);
   assign status.out_free  = !rsp_valid_ff || rsp_ready;

   // Held span: from the cursor up to the entry's left edge or the frame edge.
   assign gap_end  = cmd.sel_tail ? w_cap : e_left;
   assign cursor_u = SW'(cursor_ff);
   assign gap_len  = SW'(gap_end) - cursor_u;

   always_ff @(posedge clock) begin
      if (cmd.pend_load) begin
         pend_start_ff <= cursor_u[START_W-1:0];
         pend_len_ff   <= gap_len[LEN_W-1:0];
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_span_start     <= cmd.out_marker ? '0 : pend_start_ff;
         rsp_span_row       <= row_ff;
         rsp_span_length    <= cmd.out_marker ? '0 : pend_len_ff;
         rsp_span_valid     <= !cmd.out_marker;
         rsp_last_span      <= cmd.out_last;
         rsp_table_overflow <= overflow_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== rtl/core/excluded_rect_span_generator_core.sv =====
// ----------------------------------------------------------------------------
// excluded_rect_span_generator_core
// Emits the uncovered spans of one frame row around a table of exclusion
// rectangles.
// ----------------------------------------------------------------------------
// A clear or an append request is taken in the idle state and the block is
// ready again in the next cycle. A row request walks the stored rectangles
// through the table memory's single read port, one entry per cycle while
// finished spans can move into the output register, and takes no new
// request until the row's last result has been loaded into the output
// register. Results of a row request leave in table order, the final one
// with last_span set; a row without spans, or outside the frame, gives a
// single marker with span_valid clear. The table needs no clearing pass
// after reset.
module excluded_rect_span_generator_core #(
   parameter int MAX_RECTS  = 16,
   parameter int COORD_BITS = 13
) (
   input  logic               clock,
   input  logic               reset,
   erspg_req_if.sink          req_chan,
   erspg_rsp_if.source        rsp_chan,
   erspg_csr_if.sink          csr_chan
);
   import erspg_pkg::*;

   erspg_cmd_type    cmd;
   erspg_status_type status;

   // Register writes are always taken.
   assign csr_chan.ready = 1'b1;

   // Controller.
   erspg_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_chan.valid),
      .req_action (req_chan.action),
      .req_ready  (req_chan.ready),
      .status     (status),
      .cmd        (cmd)
   );

   // Datapath.
   erspg_dp #(
      .MAX_RECTS  (MAX_RECTS),
      .COORD_BITS (COORD_BITS)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .req_rect_left      (req_chan.rect_left),
      .req_rect_top       (req_chan.rect_top),
      .req_rect_right     (req_chan.rect_right),
      .req_rect_bottom    (req_chan.rect_bottom),
      .req_row_index      (req_chan.row_index),
      .csr_valid          (csr_chan.valid),
      .csr_index          (csr_chan.index),
      .csr_data           (csr_chan.data),
      .cmd                (cmd),
      .status             (status),
      .rsp_ready          (rsp_chan.ready),
      .rsp_valid          (rsp_chan.valid),
      .rsp_span_start     (rsp_chan.span_start),
      .rsp_span_row       (rsp_chan.span_row),
      .rsp_span_length    (rsp_chan.span_length),
      .rsp_span_valid     (rsp_chan.span_valid),
      .rsp_last_span      (rsp_chan.last_span),
      .rsp_table_overflow (rsp_chan.table_overflow)
   );

endmodule

// ===== rtl/core/erspg_checker.sv =====
// ----------------------------------------------------------------------------
// erspg_checker
// Port-level checks on the span generator, attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "excluded_rect_span_generator_core_assert.svh"

module erspg_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input logic [erspg_pkg::ACTION_W-1:0]  req_action,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [erspg_pkg::START_W-1:0]   rsp_span_start,
   input logic [erspg_pkg::LEN_W-1:0]     rsp_span_length,
   input logic                            rsp_span_valid,
   input logic                            rsp_last_span
);
   import erspg_pkg::*;

   // A stalled result stays offered.
   `ERSPG_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "result dropped while stalled")

   // A marker closes its row and carries no span.
   `ERSPG_ASSERT_IMPLY(a_marker_form, clock, reset, rsp_valid && !rsp_span_valid, rsp_last_span && (rsp_span_length == '0) && (rsp_span_start == '0), "malformed row marker")

   // A real span is never empty.
   `ERSPG_ASSERT_IMPLY(a_span_len, clock, reset, rsp_valid && rsp_span_valid, rsp_span_length != '0, "span with zero length")

   // A row request keeps the request side busy while the table is walked.
   `ERSPG_ASSERT_NEXT(a_row_busy, clock, reset, req_valid && req_ready && (req_action == ACT_ROW), !req_ready, "request taken during a row walk")

endmodule

bind excluded_rect_span_generator_core erspg_checker u_erspg_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_chan.valid),
   .req_ready       (req_chan.ready),
   .req_action      (req_chan.action),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_span_start  (rsp_chan.span_start),
   .rsp_span_length (rsp_chan.span_length),
   .rsp_span_valid  (rsp_chan.span_valid),
   .rsp_last_span   (rsp_chan.last_span)
);

// ===== bench/excluded_rect_span_generator_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// excluded_rect_span_generator_core_tb
// Drives table clears, rectangle appends and row requests into the span
// generator and checks every span result against a cycle-free predictor of
// the rectangle table. A short directed table comes first. Random band
// sequences then run under several frame sizes, with random idling on
// both channels.
// ----------------------------------------------------------------------------
module excluded_rect_span_generator_core_tb;
   import erspg_pkg::*;

   localparam int MAX_RECTS  = 16;
   localparam int COORD_BITS = 13;
   localparam int FRAME_CAP  = 1 << (COORD_BITS - 1);
   localparam int N_PHASES   = 8;
   localparam int PHASE_ITEMS = 40;
   localparam int N_DIR      = 22;

   // Action code that the block ignores.
   localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

   // One request transaction.
   typedef struct packed {
      logic [ACTION_W-1:0]      action;
      logic signed [RECT_W-1:0] left;
      logic signed [RECT_W-1:0] top;
      logic signed [RECT_W-1:0] right;
      logic signed [RECT_W-1:0] bottom;
      logic [ROW_W-1:0]         row;
   } req_t;

   // One span result transaction.
   typedef struct packed {
      logic [START_W-1:0] start;
      logic [ROW_W-1:0]   row;
      logic [LEN_W-1:0]   length;
      logic               valid;
      logic               last;
      logic               ovf;
   } span_t;

   // Directed row: a request and, where typed, its single expected span.
   typedef struct packed {
      req_t               rq;
      logic               typed;
      logic [START_W-1:0] exp_start;
      logic [LEN_W-1:0]   exp_len;
      logic               exp_valid;
   } dir_row_t;

   // Clipped rectangle as the predictor stores it.
   typedef struct {
      int left;
      int top;
      int right;
      int bottom;
   } clip_rect_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic no_idle = 1'b0;

   erspg_req_if req_if ();
   erspg_rsp_if rsp_if ();
   erspg_csr_if csr_if ();

   // Predictor state.
   logic [CFG_W-1:0] frame_w = FRAME_WIDTH_RESET;
   logic [CFG_W-1:0] frame_h = FRAME_HEIGHT_RESET;
   clip_rect_t       rect_store [MAX_RECTS];
   int               rect_count = 0;
   logic             table_ovf = 1'b0;
   span_t            expected_spans [$];

   int fail_count = 0;
   int report_count = 0;
   int req_count = 0;
   int span_count = 0;
   int ovf_span_count = 0;

   // Frame sizes of the random phases; phase 6 is drawn at run time.
   int phase_w [N_PHASES] = '{1, 4096, 8191, 0, 100, 33, 0, 640};
   int phase_h [N_PHASES] = '{1, 4096, 8191, 100, 0, 20, 0, 480};

   dir_row_t dir_table [N_DIR] = '{
      '{'{ACT_ROW, 16'sh0, 16'sh0, 16'sh0, 16'sh0, 12'd0}, 1'b1, 12'd0, 13'd640, 1'b1},
      '{'{ACT_ROW, 16'sh0, 16'sh0, 16'sh0, 16'sh0, 12'd4095}, 1'b1, 12'd0, 13'd0, 1'b0},
      '{'{ACT_ROW, 16'sh0, 16'sh0, 16'sh0, 16'sh0, 12'd479}, 1'b1, 12'd0, 13'd640, 1'b1},
      '{'{ACT_ROW, 16'sh0, 16'sh0, 16'sh0, 16'sh0, 12'd480}, 1'b1, 12'd0, 13'd0, 1'b0},
      '{'{ACT_UNUSED, 16'shFFFF, 16'shFFFF, 16'shFFFF, 16'shFFFF, 12'hFFF},
        1'b0, 12'd0, 13'd0, 1'b0},
      '{'{ACT_APPEND, 16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 12'd0},
        1'b0, 12'd0, 13'd0, 1'b0},
      '{'{ACT_ROW, 16'sh0, 16'sh0, 16'sh0, 16'sh0, 12'd0}, 1'b1, 12'd0, 13'd0, 1'b0},
      '{'{ACT_ROW, 16'sh0, 16'sh0, 16'sh0, 16'sh0, 12'd479}, 1'b1, 12'd0, 13'd0, 1'b0},
      '{'{ACT_CLEAR, 16'sh0, 16'sh0, 16'sh0, 16'sh0, 12'd0}, 1'b0, 12'd0, 13'd0, 1'b0},
      '{'{ACT_APPEND, -16'sd5, -16'sd5, 16'sd3, 16'sd3, 12'd0}, 1'b0, 12'd0, 13'd0, 1'b0},
      '{'{ACT_APPEND, 16'sd10, 16'sd0, 16'sd20, 16'sd480, 12'd0},
        1'b0, 12'd0, 13'd0, 1'b0},
      '{'{ACT_APPEND, 16'sd20, 16'sd0, 16'sd40, 16'sd10, 12'd0}, 1'b0, 12'd0, 13'd0, 1'b0},
      '{'{ACT_APPEND, 16'sd5, 16'sd5, 16'sd5, 16'sd10, 12'd0}, 1'b0, 12'd0, 13'd0, 1'b0},
      '{'{ACT_APPEND, 16'sd300, 16'sd600, 16'sd400, 16'sd700, 12'd0},
        1'b0, 12'd0, 13'd0, 1'b0},
      '{'{ACT_APPEND, 16'sd15, 16'sd2, 16'sd30, 16'sd4, 12'd0}, 1'b0, 12'd0, 13'd0, 1'b0},
      '{'{ACT_APPEND, 16'sd600, 16'sd0, 16'sh7FFF, 16'sd480, 12'd0},
        1'b0, 12'd0, 13'd0, 1'b0},
      '{'{ACT_ROW, 16'sh0, 16'sh0, 16'sh0, 16'sh0, 12'd0}, 1'b0, 12'd0, 13'd0, 1'b0},
      '{'{ACT_ROW, 16'sh0, 16'sh0, 16'sh0, 16'sh0, 12'd2}, 1'b0, 12'd0, 13'd0, 1'b0},
      '{'{ACT_ROW, 16'sh0, 16'sh0, 16'sh0, 16'sh0, 12'd100}, 1'b0, 12'd0, 13'd0, 1'b0},
      '{'{ACT_ROW, 16'sh0, 16'sh0, 16'sh0, 16'sh0, 12'd479}, 1'b0, 12'd0, 13'd0, 1'b0},
      '{'{ACT_CLEAR, 16'sh0, 16'sh0, 16'sh0, 16'sh0, 12'd0}, 1'b0, 12'd0, 13'd0, 1'b0},
      '{'{ACT_ROW, 16'sh0, 16'sh0, 16'sh0, 16'sh0, 12'd10}, 1'b1, 12'd0, 13'd640, 1'b1}
   };

   excluded_rect_span_generator_core #(
      .MAX_RECTS (MAX_RECTS),
      .COORD_BITS(COORD_BITS)
   ) DUT (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_if.sink),
      .rsp_chan(rsp_if.source),
      .csr_chan(csr_if.sink)
   );

   // Free-running clock, 12 ns period.
   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // Frame dimensions are limited to the coordinate range for every use.
   function automatic int cap_dim(logic [CFG_W-1:0] v);
      return (int'(v) > FRAME_CAP) ? FRAME_CAP : int'(v);
   endfunction

   // Applies one accepted transaction to the table and queues the spans
   // that it produces.
   function automatic void predict_spans(req_t it);
      int w, h, row_n, cursor, len, l, t, r, b, i;
      span_t row_out [$];
      span_t s;
      w = cap_dim(frame_w);
      h = cap_dim(frame_h);
      case (it.action)
         ACT_CLEAR: begin
            rect_count = 0;
            table_ovf = 1'b0;
         end
         ACT_APPEND: begin
            if (rect_count >= MAX_RECTS) begin
               table_ovf = 1'b1;
            end else begin
               l = int'($signed(it.left));
               t = int'($signed(it.top));
               r = int'($signed(it.right));
               b = int'($signed(it.bottom));
               if (l < 0) l = 0;
               if (t < 0) t = 0;
               if (r > w) r = w;
               if (b > h) b = h;
               // Anything clipped away entirely is kept as an empty entry.
               if (l >= r || t >= b) begin
                  l = 0;
                  t = 0;
                  r = 0;
                  b = 0;
               end
               rect_store[rect_count] = '{l, t, r, b};
               rect_count++;
            end
         end
         ACT_ROW: begin
            row_n = int'(it.row);
            s = '0;
            s.row = it.row;
            s.ovf = table_ovf;
            s.valid = 1'b1;
            if (w > 0 && h > 0 && row_n < h) begin
               cursor = 0;
               for (i = 0; i < rect_count; i++) begin
                  if (rect_store[i].left >= rect_store[i].right ||
                      rect_store[i].top >= rect_store[i].bottom) continue;
                  if (row_n >= rect_store[i].top && row_n < rect_store[i].bottom) begin
                     len = rect_store[i].left - cursor;
                     if (len > 0) begin
                        s.start = cursor[START_W-1:0];
                        s.length = len[LEN_W-1:0];
                        row_out.push_back(s);
                     end
                     // The cursor may step backwards on out-of-order tables.
                     cursor = rect_store[i].right;
                  end
               end
               len = w - cursor;
               if (len > 0) begin
                  s.start = cursor[START_W-1:0];
                  s.length = len[LEN_W-1:0];
                  row_out.push_back(s);
               end
            end
            // A row with nothing uncovered, or outside the frame, gives a marker.
            if (row_out.size() == 0) begin
               s.start = '0;
               s.length = '0;
               s.valid = 1'b0;
               row_out.push_back(s);
            end
            row_out[row_out.size() - 1].last = 1'b1;
            foreach (row_out[k]) expected_spans.push_back(row_out[k]);
         end
         default: begin
         end
      endcase
   endfunction

   // Presents one request and waits for its transaction; a typed
   // expectation replaces the predicted one for directed rows.
   task automatic send_req(req_t it, logic typed, span_t exp);
      if (!no_idle) begin
         while ($urandom_range(0, 99) < 35) begin
            req_if.valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_if.valid <= 1'b1;
      req_if.action <= it.action;
      req_if.rect_left <= it.left;
      req_if.rect_top <= it.top;
      req_if.rect_right <= it.right;
      req_if.rect_bottom <= it.bottom;
      req_if.row_index <= it.row;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      req_count++;
      if (typed) expected_spans.push_back(exp);
      else predict_spans(it);
   endtask

   // Row request, mostly inside the frame.
   task automatic send_row(int hc);
      req_t it;
      it = '0;
      it.action = ACT_ROW;
      if (hc > 0 && $urandom_range(0, 7) != 0) it.row = ROW_W'($urandom_range(0, hc - 1));
      else it.row = ROW_W'($urandom_range(0, 4095));
      send_req(it, 1'b0, '0);
   endtask

   // Register write; the caller lowers valid after its last write.
   task automatic write_reg(csr_index_type idx, logic [CFG_W-1:0] val);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data <= val;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
      if (idx == CSR_FRAME_WIDTH) frame_w = val;
      else frame_h = val;
   endtask

   // Waits until every expected span has arrived and the block has gone idle.
   task automatic settle();
      while (expected_spans.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   // Random phase: mostly well-formed band loads followed by row requests,
   // some table fills past capacity, and some noise.
   task automatic run_phase(int budget);
      int sent, kind, n, k, x, span_w, l, r, t, b, wc, hc;
      req_t it;
      sent = 0;
      while (sent < budget) begin
         wc = cap_dim(frame_w);
         hc = cap_dim(frame_h);
         span_w = (wc > 8) ? wc / 4 : 2;
         kind = $urandom_range(0, 99);
         if (kind < 70) begin
            // Clear, then rectangles loaded left to right within a band.
            if ($urandom_range(0, 4) != 0) begin
               it = '0;
               it.action = ACT_CLEAR;
               send_req(it, 1'b0, '0);
               sent++;
            end
            n = $urandom_range(1, 7);
            x = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, span_w);
            for (k = 0; k < n; k++) begin
               l = x + (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, span_w));
               r = l + $urandom_range(1, span_w);
               t = $urandom_range(0, (hc > 1) ? hc - 1 : 1);
               b = t + $urandom_range(1, (hc > 1) ? hc : 2);
               if ($urandom_range(0, 7) == 0) l = l - $urandom_range(1, 40);
               if ($urandom_range(0, 9) == 0) t = t - $urandom_range(1, 40);
               it = '0;
               it.action = ACT_APPEND;
               it.left = l[RECT_W-1:0];
               it.top = t[RECT_W-1:0];
               it.right = r[RECT_W-1:0];
               it.bottom = b[RECT_W-1:0];
               send_req(it, 1'b0, '0);
               sent++;
               x = r;
            end
            repeat ($urandom_range(2, 5)) begin
               send_row(hc);
               sent++;
            end
         end else if (kind < 80) begin
            // Load up to or past the table capacity to raise the overflow flag.
            repeat ($urandom_range(16, 20)) begin
               l = $urandom_range(0, wc);
               r = l + $urandom_range(0, span_w);
               t = $urandom_range(0, hc);
               b = t + $urandom_range(0, (hc > 1) ? hc : 2);
               it = '0;
               it.action = ACT_APPEND;
               it.left = l[RECT_W-1:0];
               it.top = t[RECT_W-1:0];
               it.right = r[RECT_W-1:0];
               it.bottom = b[RECT_W-1:0];
               send_req(it, 1'b0, '0);
               sent++;
            end
            repeat (2) begin
               send_row(hc);
               sent++;
            end
         end else begin
            // Noise: any action with raw field values.
            repeat ($urandom_range(1, 4)) begin
               it.action = ACTION_W'($urandom_range(0, 3));
               it.left = RECT_W'($urandom);
               it.top = RECT_W'($urandom);
               it.right = RECT_W'($urandom);
               it.bottom = RECT_W'($urandom);
               it.row = ROW_W'($urandom);
               send_req(it, 1'b0, '0);
               if (it.action != ACT_UNUSED) sent++;
            end
         end
      end
   endtask

   // Result side: random back-pressure and the span check.
   always @(posedge clock) begin : span_check
      span_t got;
      span_t exp;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            got = '{rsp_if.span_start, rsp_if.span_row, rsp_if.span_length,
                    rsp_if.span_valid, rsp_if.last_span, rsp_if.table_overflow};
            span_count++;
            if (got.ovf) ovf_span_count++;
            if (expected_spans.size() == 0) begin
               fail_count++;
               if (report_count < 10) begin
                  report_count++;
                  $display("unexpected span: start %0d row %0d len %0d valid %b last %b ovf %b",
                           got.start, got.row, got.length, got.valid, got.last, got.ovf);
               end
            end else begin
               exp = expected_spans.pop_front();
               if (got.start !== exp.start || got.row !== exp.row ||
                   got.length !== exp.length || got.valid !== exp.valid ||
                   got.last !== exp.last || got.ovf !== exp.ovf) begin
                  fail_count++;
                  if (report_count < 10) begin
                     report_count++;
                     $display("span mismatch: expected start %0d row %0d len %0d valid %b last %b ovf %b",
                              exp.start, exp.row, exp.length, exp.valid, exp.last, exp.ovf);
                     $display("               got      start %0d row %0d len %0d valid %b last %b ovf %b",
                              got.start, got.row, got.length, got.valid, got.last, got.ovf);
                  end
               end
            end
         end
         rsp_if.ready <= no_idle || ($urandom_range(0, 99) >= 35);
      end
   end

   // Stimulus sequence.
   initial begin : stimulus
      int i, p;
      span_t exp;
      req_if.valid = 1'b0;
      req_if.action = ACT_CLEAR;
      req_if.rect_left = '0;
      req_if.rect_top = '0;
      req_if.rect_right = '0;
      req_if.rect_bottom = '0;
      req_if.row_index = '0;
      csr_if.valid = 1'b0;
      csr_if.index = CSR_FRAME_WIDTH;
      csr_if.data = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed table under the reset frame size.
      for (i = 0; i < N_DIR; i++) begin
         exp = '0;
         exp.start = dir_table[i].exp_start;
         exp.row = dir_table[i].rq.row;
         exp.length = dir_table[i].exp_len;
         exp.valid = dir_table[i].exp_valid;
         exp.last = 1'b1;
         send_req(dir_table[i].rq, dir_table[i].typed, exp);
      end
      req_if.valid <= 1'b0;

      // Random phases, each under its own frame size.
      for (p = 0; p < N_PHASES; p++) begin
         settle();
         if (p == 6) begin
            phase_w[p] = $urandom_range(1, 4096);
            phase_h[p] = $urandom_range(1, 4096);
         end
         write_reg(CSR_FRAME_WIDTH, phase_w[p][CFG_W-1:0]);
         write_reg(CSR_FRAME_HEIGHT, phase_h[p][CFG_W-1:0]);
         csr_if.valid <= 1'b0;
         // One whole phase runs without any idling on either side.
         no_idle = (p == 1);
         run_phase(PHASE_ITEMS);
         req_if.valid <= 1'b0;
      end
      settle();
      no_idle = 1'b0;

      $display("Accepted %0d requests over %0d frame sizes; checked %0d span results,",
               req_count, N_PHASES + 1, span_count);
      $display("%0d of them with the overflow flag set; %0d failures.",
               ovf_span_count, fail_count);
      if (fail_count == 0) begin
         $display("excluded_rect_span_generator_core_tb OK");
      end else begin
         $display("excluded_rect_span_generator_core_tb NOT OK");
      end
      $finish;
   end

   // Watchdog.
   initial begin
      #10ms;
      $display("excluded_rect_span_generator_core_tb NOT OK");
      $finish;
   end

endmodule
